/* hdl/ipv6fmt_pkg.sv */
// Shared types, constants and helper functions for the IPv6 address text formatter.
// Used by ipv6fmt_scan, ipv6fmt_emit and the top level; depends on nothing.
`default_nettype none

package ipv6fmt_pkg;

  localparam int NUM_WORDS = 8;
  localparam int PFX_WORDS = 6;

  typedef logic [NUM_WORDS-1:0][15:0] word_vec_t;

  // longest zero run (already checked against the two-word minimum) and NAT64 hit
  typedef struct packed {
    logic       valid;
    logic [2:0] base;
    logic [3:0] len;
    logic       nat64;
  } zrun_t;

  localparam logic [1:0] REG_NAT64_ENABLE = 2'd0;
  localparam logic [1:0] REG_PREFIX_HIGH  = 2'd1;
  localparam logic [1:0] REG_PREFIX_LOW   = 2'd2;

  localparam logic [6:0] CH_COLON      = 7'h3a;
  localparam logic [6:0] CH_DOT        = 7'h2e;
  localparam logic [6:0] CH_ZERO       = 7'h30;
  localparam logic [6:0] CH_ALPHA_BASE = 7'h57;

  localparam logic [15:0] WORD_ALL_ONES = 16'hffff;
  localparam logic [2:0]  WORD_DOTTED   = 3'd6;
  localparam logic [2:0]  WORD_LAST     = 3'd7;
  localparam logic [1:0]  BYTE_LAST     = 2'd3;

  function automatic logic [6:0] hex_char(input logic [3:0] nib);
    logic [6:0] c;
    if (nib < 4'd10) begin
      c = CH_ZERO + {3'b000, nib};
    end else begin
      c = CH_ALPHA_BASE + {3'b000, nib};
    end
    return c;
  endfunction

  // position of the leading hex digit, nibble 3 being the top one
  function automatic logic [1:0] hex_lead(input logic [15:0] w);
    logic [1:0] p;
    priority if (w[15:12] != 4'h0) begin
      p = 2'd3;
    end else if (w[11:8] != 4'h0) begin
      p = 2'd2;
    end else if (w[7:4] != 4'h0) begin
      p = 2'd1;
    end else begin
      p = 2'd0;
    end
    return p;
  endfunction

  // position of the leading decimal digit, 2 being hundreds
  function automatic logic [1:0] dec_lead(input logic [7:0] v);
    logic [1:0] p;
    priority if (v >= 8'd100) begin
      p = 2'd2;
    end else if (v >= 8'd10) begin
      p = 2'd1;
    end else begin
      p = 2'd0;
    end
    return p;
  endfunction

  function automatic logic [3:0] dec_digit(input logic [7:0] v, input logic [1:0] pos);
    logic [1:0]  hund;
    logic [6:0]  rem;
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  ones;
    logic [3:0]  d;
    priority if (v >= 8'd200) begin
      hund = 2'd2;
      rem  = 7'(v - 8'd200);
    end else if (v >= 8'd100) begin
      hund = 2'd1;
      rem  = 7'(v - 8'd100);
    end else begin
      hund = 2'd0;
      rem  = v[6:0];
    end
    // divide by ten through the reciprocal 205/2048, exact below 1029
    prod = {8'h00, rem} * 15'd205;
    tens = prod[14:11];
    ones = rem - 7'({3'b000, tens} * 7'd10);
    unique case (pos)
      2'd2:    d = {2'b00, hund};
      2'd1:    d = tens;
      default: d = ones[3:0];
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

/* hdl/ipv6fmt_scan.sv */
// Zero-run and NAT64 prefix scan: one 16-bit word through a shared compare per cycle.
// Depends on ipv6fmt_pkg.
`default_nettype none

module ipv6fmt_scan import ipv6fmt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  logic      nat64_en,
  input  word_vec_t words,
  input  word_vec_t pfx,
  output logic      done,
  output zrun_t     zr
);

  logic       busy;
  logic [3:0] cnt;
  logic       cur_v;
  logic [2:0] cur_b;
  logic [3:0] cur_len;
  logic       best_v;
  logic [2:0] best_b;
  logic [3:0] best_len;
  logic       match;

  logic [15:0] word_sel;
  logic        is_zero;
  logic        pfx_hit;

  // one step past the last word acts as a nonzero word to close a trailing run
  always_comb begin
    word_sel = cnt[3] ? 16'h0000 : words[cnt[2:0]];
    is_zero  = !cnt[3] && (word_sel == 16'h0000);
    pfx_hit  = (cnt >= 4'(PFX_WORDS)) || (word_sel == pfx[cnt[2:0]]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
      cur_v  <= 1'b0;
      best_v <= 1'b0;
      match  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        cnt    <= '0;
        cur_v  <= 1'b0;
        best_v <= 1'b0;
        match  <= nat64_en;
      end else if (busy) begin
        cnt <= cnt + 4'd1;
        if (cnt == 4'(NUM_WORDS)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        if (!pfx_hit) begin
          match <= 1'b0;
        end
        if (is_zero) begin
          if (cur_v) begin
            cur_len <= cur_len + 4'd1;
          end else begin
            cur_v   <= 1'b1;
            cur_b   <= cnt[2:0];
            cur_len <= 4'd1;
          end
        end else if (cur_v) begin
          cur_v <= 1'b0;
          if (!best_v || (cur_len > best_len)) begin
            best_v   <= 1'b1;
            best_b   <= cur_b;
            best_len <= cur_len;
          end
        end
      end
    end
  end

  assign zr.valid = best_v && (best_len >= 4'd2);
  assign zr.base  = best_b;
  assign zr.len   = best_len;
  assign zr.nat64 = match;

endmodule

`default_nettype wire

/* hdl/ipv6fmt_emit.sv */
// Character sequencer: walks words, hex digits and dotted-decimal bytes of one address,
// taking the next only from idle, into a registered output stage. Depends on ipv6fmt_pkg.
`default_nettype none

module ipv6fmt_emit import ipv6fmt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  word_vec_t  words,
  input  zrun_t      zr,
  input  logic       m_tready,
  output logic       m_tvalid,
  output logic [7:0] m_tdata,   // [6:0] text_char, [7] zero
  output logic       m_tlast,   // is_last
  output logic       done
);

  typedef enum logic [5:0] {
    E_IDLE = 6'b000001,
    E_WORD = 6'b000010,
    E_BODY = 6'b000100,
    E_DEC  = 6'b001000,
    E_DOT  = 6'b010000,
    E_TAIL = 6'b100000
  } emit_state_t;

  emit_state_t state, state_next;
  logic [2:0]  wi, wi_next;
  logic [1:0]  nib, nib_next;
  logic [1:0]  db, db_next;
  logic [1:0]  dp, dp_next;

  logic            adv;
  logic [6:0]      ch;
  logic            last;
  logic            dotted;
  logic [3:0]      run_end;
  logic [15:0]     cur_word;
  logic [3:0][7:0] dbytes;
  logic [7:0]      cur_byte;
  logic [7:0]      nxt_byte;

  assign adv      = (state != E_IDLE) && (!m_tvalid || m_tready);
  assign dotted   = zr.nat64 || (zr.valid && (zr.base == 3'd0) &&
                    ((zr.len == 4'd6) || ((zr.len == 4'd5) && (words[5] == WORD_ALL_ONES))));
  assign run_end  = {1'b0, zr.base} + zr.len;
  assign cur_word = words[wi];
  assign dbytes   = {words[7][7:0], words[7][15:8], words[6][7:0], words[6][15:8]};
  assign cur_byte = dbytes[db];
  assign nxt_byte = dbytes[db + 2'd1];

  always_comb begin
    state_next = state;
    wi_next    = wi;
    nib_next   = nib;
    db_next    = db;
    dp_next    = dp;
    ch         = CH_COLON;
    last       = 1'b0;
    unique case (state)
      E_IDLE: begin
        if (start) begin
          wi_next = 3'd0;
          if (zr.valid && (zr.base == 3'd0)) begin
            state_next = E_WORD;
          end else begin
            state_next = E_BODY;
            nib_next   = hex_lead(words[0]);
          end
        end
      end
      E_WORD: begin
        if (adv) begin
          if (zr.valid && (wi == zr.base)) begin
            if (run_end == 4'(NUM_WORDS)) begin
              state_next = E_TAIL;
            end else begin
              wi_next = run_end[2:0];
            end
          end else if ((wi == WORD_DOTTED) && dotted) begin
            state_next = E_DEC;
            db_next    = 2'd0;
            dp_next    = dec_lead(dbytes[0]);
          end else begin
            state_next = E_BODY;
            nib_next   = hex_lead(cur_word);
          end
        end
      end
      E_BODY: begin
        ch = hex_char(cur_word[{nib, 2'b00} +: 4]);
        if (nib == 2'd0) begin
          last = (wi == WORD_LAST);
        end
        if (adv) begin
          if (nib != 2'd0) begin
            nib_next = nib - 2'd1;
          end else if (wi == WORD_LAST) begin
            state_next = E_IDLE;
          end else begin
            wi_next    = wi + 3'd1;
            state_next = E_WORD;
          end
        end
      end
      E_DEC: begin
        ch   = CH_ZERO + {3'b000, dec_digit(cur_byte, dp)};
        last = (dp == 2'd0) && (db == BYTE_LAST);
        if (adv) begin
          if (dp != 2'd0) begin
            dp_next = dp - 2'd1;
          end else if (db == BYTE_LAST) begin
            state_next = E_IDLE;
          end else begin
            state_next = E_DOT;
          end
        end
      end
      E_DOT: begin
        ch = CH_DOT;
        if (adv) begin
          db_next    = db + 2'd1;
          dp_next    = dec_lead(nxt_byte);
          state_next = E_DEC;
        end
      end
      E_TAIL: begin
        last = 1'b1;
        if (adv) begin
          state_next = E_IDLE;
        end
      end
      default: begin
        state_next = E_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= E_IDLE;
      m_tvalid <= 1'b0;
      done     <= 1'b0;
    end else begin
      state <= state_next;
      done  <= adv && last;
      if (adv) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    wi  <= wi_next;
    nib <= nib_next;
    db  <= db_next;
    dp  <= dp_next;
    if (adv) begin
      m_tdata <= {1'b0, ch};
      m_tlast <= last;
    end
  end

endmodule

`default_nettype wire

/* hdl/ipv6_address_text_formatter.sv */
// IPv6 address text formatter, top level.
// Depends on ipv6fmt_pkg, ipv6fmt_scan and ipv6fmt_emit.
//
// Usage:
//   Slave stream: one 128-bit address per word, addr_high in s_tdata[63:0],
//   addr_low in s_tdata[127:64]. Master stream: one ASCII character per word
//   in m_tdata[6:0], m_tlast high on the final character of an address.
//   APB port: nat64_enable at 0x00, nat64_prefix_high at 0x08,
//   nat64_prefix_low at 0x10; 64-bit data, pready tied high, no wait states.
// Timing:
//   After an address is taken, the scan unit compares one 16-bit word per
//   cycle against zero and the NAT64 prefix, then takes a closing step past
//   the last word, and its done strobe starts the character sequencer.
//   Characters then enter the output register at one per cycle unless the
//   output register holds an unaccepted character, 2 to 45 of them per address.
//   s_tready is low from the accepted word until the cycle after the last
//   character is loaded into the output register.
// Stall: when m_tready is low the output register holds its word and the
//   sequencer waits; nothing is dropped.
// Reset: rst (synchronous) clears the sequencers, the output valid and the
//   configuration registers.
`default_nettype none

module ipv6_address_text_formatter import ipv6fmt_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,   // [63:0] addr_high, [127:64] addr_low
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [7:0]   m_tdata,   // [6:0] text_char, [7] zero
  output logic         m_tlast,   // is_last
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready
);

  typedef enum logic [2:0] {
    T_IDLE = 3'b001,
    T_SCAN = 3'b010,
    T_EMIT = 3'b100
  } top_state_t;

  top_state_t state;

  logic        nat64_enable;
  logic [63:0] nat64_prefix_high;
  logic [31:0] nat64_prefix_low;
  logic [63:0] addr_high;
  logic [63:0] addr_low;

  logic       accept;
  logic       wr_en;
  logic [1:0] reg_idx;
  word_vec_t  words;
  word_vec_t  pfx;
  zrun_t      zr;
  logic       scan_done;
  logic       emit_done;

  assign accept   = s_tvalid && s_tready;
  assign s_tready = (state == T_IDLE);
  assign pready   = 1'b1;
  assign wr_en    = psel && penable && pwrite;
  assign reg_idx  = paddr[4:3];

  assign words = {addr_low[15:0],  addr_low[31:16],  addr_low[47:32],  addr_low[63:48],
                  addr_high[15:0], addr_high[31:16], addr_high[47:32], addr_high[63:48]};
  assign pfx   = {32'h0000_0000, nat64_prefix_low[15:0], nat64_prefix_low[31:16],
                  nat64_prefix_high[15:0], nat64_prefix_high[31:16],
                  nat64_prefix_high[47:32], nat64_prefix_high[63:48]};

  always_ff @(posedge clk) begin
    if (rst) begin
      nat64_enable      <= 1'b0;
      nat64_prefix_high <= '0;
      nat64_prefix_low  <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_NAT64_ENABLE: nat64_enable      <= pwdata[0];
        REG_PREFIX_HIGH:  nat64_prefix_high <= pwdata;
        REG_PREFIX_LOW:   nat64_prefix_low  <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_NAT64_ENABLE: prdata = {63'd0, nat64_enable};
      REG_PREFIX_HIGH:  prdata = nat64_prefix_high;
      REG_PREFIX_LOW:   prdata = {32'd0, nat64_prefix_low};
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
    end else begin
      unique case (state)
        T_IDLE: if (accept) state <= T_SCAN;
        T_SCAN: if (scan_done) state <= T_EMIT;
        T_EMIT: if (emit_done) state <= T_IDLE;
        default: state <= T_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      addr_high <= s_tdata[63:0];
      addr_low  <= s_tdata[127:64];
    end
  end

  ipv6fmt_scan u_scan (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .nat64_en (nat64_enable),
    .words    (words),
    .pfx      (pfx),
    .done     (scan_done),
    .zr       (zr)
  );

  ipv6fmt_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .start    (scan_done),
    .words    (words),
    .zr       (zr),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .done     (emit_done)
  );

endmodule

`default_nettype wire

/* hdl/ipv6fmt_checker.sv */
// Port-level checks for the IPv6 address text formatter, bound to the top level.
// Depends on ipv6_address_text_formatter.
`default_nettype none

module ipv6fmt_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast
);

  a_reset_state: assert property (@(posedge clk)
    rst |=> (!m_tvalid && s_tready))
    else $error("block not idle after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("new address taken while scan runs");

  a_ascii_only: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !m_tdata[7])
    else $error("character outside 7-bit range");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
    else $error("output word changed under stall");

endmodule

bind ipv6_address_text_formatter ipv6fmt_checker u_ipv6fmt_checker (.*);

`default_nettype wire
